[sv/tpm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the trie multi-pattern matcher.
// No dependencies; imported by the controller, the datapath and the top level.
package tpm_pkg;

  localparam int unsigned STATES_DEF  = 256;
  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned CHARS       = 256;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned LEN_W      = 7;

  typedef enum logic [1:0] {
    OP_TRANS = 2'd0,
    OP_XLAT  = 2'd1,
    OP_TEXT  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XLAT,
    ST_RING,
    ST_LOOK,
    ST_EMIT
  } ctl_state_e;

  // outcome of one trie step
  typedef enum logic [1:0] {
    ACT_END,
    ACT_EMIT,
    ACT_NEW,
    ACT_RING
  } act_e;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic xlat;
    logic ring;
    logic look;
    logic emit;
  } tpm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_text;
    logic decided;
    act_e act;
    logic last;
    logic out_free;
  } tpm_sts_t;

endpackage

[sv/tpm_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the trie matcher: memory clear, intake, table steps, result.
// Depends on tpm_pkg; drives the datapath only through tpm_cmd_t.
module tpm_ctrl
  import tpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tpm_sts_t sts_i,
  output tpm_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       acc;

  assign acc = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc && sts_i.is_text && !sts_i.decided) state_d = ST_XLAT;
      end
      ST_XLAT: state_d = ST_LOOK;
      ST_RING: state_d = ST_LOOK;
      ST_LOOK: begin
        case (sts_i.act)
          ACT_EMIT: state_d = ST_EMIT;
          ACT_NEW:  state_d = ST_LOOK;
          ACT_RING: state_d = ST_RING;
          ACT_END:  state_d = sts_i.last ? ST_EMIT : ST_IDLE;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE:  cmd_o.accept   = acc;
      ST_XLAT:  cmd_o.xlat     = 1'b1;
      ST_RING:  cmd_o.ring     = 1'b1;
      ST_LOOK:  cmd_o.look     = 1'b1;
      ST_EMIT:  cmd_o.emit     = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

[sv/tpm_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the trie matcher: transition, translation and replay memories,
// per-string match state and the result register. Depends on tpm_pkg.
module tpm_datapath
  import tpm_pkg::*;
#(
  parameter int unsigned STATES  = STATES_DEF,
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tpm_cmd_t              cmd_i,
  output tpm_sts_t              sts_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [IN_USER_W-1:0]  in_user_i,
  input  logic                  in_last_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_user_o
);

  localparam int unsigned TDEPTH = CHARS * STATES;
  localparam int unsigned TAW    = $clog2(TDEPTH);
  localparam int unsigned RAW    = $clog2(MAX_LEN + 1);
  localparam int unsigned RDEPTH = 1 << RAW;
  localparam int unsigned IW     = $clog2(MAX_LEN + 2);

  // input fields
  logic [7:0] in_code, in_col, in_nst, in_tag, in_tc;
  assign in_code = in_data_i[7:0];
  assign in_col  = in_data_i[15:8];
  assign in_nst  = in_data_i[23:16];
  assign in_tag  = in_data_i[31:24];
  assign in_tc   = in_data_i[39:32];

  logic acc_text, acc_trans, acc_xlat;
  assign acc_text  = cmd_i.accept && (in_user_i == OP_TEXT);
  assign acc_trans = cmd_i.accept && (in_user_i == OP_TRANS) && (in_code != 8'd0)
                     && (32'(in_col) < STATES);
  assign acc_xlat  = cmd_i.accept && (in_user_i == OP_XLAT);

  // memories
  logic [15:0]    tmem [TDEPTH];
  logic [7:0]     xmem [CHARS];
  logic [7:0]     rmem [RDEPTH];
  logic [CHARS-1:0] xvalid_q;

  logic [TAW-1:0] clr_q;
  logic           twe;
  logic [TAW-1:0] twaddr;
  logic [15:0]    twdata;

  logic [15:0]    trd_q;
  logic           byp_q;
  logic [7:0]     bval_q;
  logic [7:0]     xrd_q, xaddr_q;
  logic           xv_q;
  logic [7:0]     rrd_q;

  // per-string and loop state
  logic             anchored_q;
  logic [POS_W-1:0] pos_q, ms_q, base_q;
  logic [7:0]       cur_st_q, st_q, newc_q;
  logic [IW-1:0]    cnt_q, nidx_q, i_q, sidx_q;
  logic             bv_q, decided_q, last_q, ovf_q;
  logic [7:0]       bp_q;
  logic [IW-1:0]    bl_q;

  logic             out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic             out_user_q;

  // translation result
  logic [7:0] newc;
  assign newc = xv_q ? xrd_q : xaddr_q;

  // one trie step
  logic [15:0]   e;
  logic [7:0]    e_tag;
  logic [IW-1:0] sidx_e, len, i_n, sidx_n;
  logic [7:0]    st_n;
  logic          bv_n, emit_n, ovf_n;
  logic [7:0]    bp_n;
  logic [IW-1:0] bl_n;
  act_e          act;

  assign e     = byp_q ? {8'd0, bval_q} : trd_q;
  assign e_tag = e[15:8];

  always_comb begin
    sidx_e = (st_q == 8'd0) ? i_q : sidx_q;
    len    = IW'(i_q - sidx_e + IW'(1));
    bv_n   = bv_q;
    bp_n   = bp_q;
    bl_n   = bl_q;
    emit_n = 1'b0;
    ovf_n  = 1'b0;
    st_n   = 8'd0;
    sidx_n = sidx_q;
    i_n    = IW'(i_q + IW'(1));
    if (e != 16'd0) begin
      sidx_n = sidx_e;
      if (len > IW'(MAX_LEN)) begin
        emit_n = 1'b1;
        ovf_n  = 1'b1;
        st_n   = st_q;
      end else begin
        st_n = e[7:0];
        if (e_tag != 8'd0) begin
          bv_n = 1'b1;
          bp_n = 8'(e_tag - 8'd1);
          bl_n = len;
          if (e[7:0] == 8'd0) emit_n = 1'b1;
        end
      end
    end else begin
      if (anchored_q || (st_q != 8'd0 && bv_q)) emit_n = 1'b1;
      if (st_q != 8'd0) i_n = IW'(sidx_q + IW'(1));
    end
    if (emit_n)             act = ACT_EMIT;
    else if (i_n > nidx_q)  act = ACT_END;
    else if (i_n == nidx_q) act = ACT_NEW;
    else                    act = ACT_RING;
  end

  // lookup request
  logic           lk_req;
  logic [7:0]     lk_c, lk_st;
  logic [TAW-1:0] lk_addr;
  logic           ring_req;
  logic [RAW-1:0] ring_addr;

  always_comb begin
    lk_c  = newc_q;
    lk_st = st_n;
    if (cmd_i.xlat) begin
      lk_c  = newc;
      lk_st = st_q;
    end else if (cmd_i.ring) begin
      lk_c  = rrd_q;
      lk_st = st_q;
    end
  end
  assign lk_req   = cmd_i.xlat || cmd_i.ring || (cmd_i.look && act == ACT_NEW);
  assign lk_addr  = TAW'(32'(lk_c) * STATES + 32'(lk_st));
  assign ring_req = cmd_i.look && (act == ACT_RING);
  assign ring_addr = RAW'(base_q[RAW-1:0] + RAW'(i_n));

  assign twe    = cmd_i.clr_step || acc_trans;
  assign twaddr = cmd_i.clr_step ? clr_q : TAW'(32'(in_code) * STATES + 32'(in_col));
  assign twdata = cmd_i.clr_step ? 16'd0 : {in_tag, in_nst};

  always_ff @(posedge clk_i) begin
    if (twe) tmem[twaddr] <= twdata;
    if (lk_req) trd_q <= tmem[lk_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_xlat) xmem[in_code] <= in_tc;
    if (acc_text) xrd_q <= xmem[in_code];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xlat) rmem[RAW'(base_q[RAW-1:0] + RAW'(nidx_q))] <= newc;
    if (ring_req) rrd_q <= rmem[ring_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xvalid_q <= '0;
    end else if (acc_xlat) begin
      xvalid_q[in_code] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= TAW'(clr_q + TAW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchored_q <= 1'b0;
    end else if (cfg_we_i) begin
      anchored_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_text) begin
      xaddr_q <= in_code;
      xv_q    <= xvalid_q[in_code];
      base_q  <= (cur_st_q != 8'd0) ? ms_q : pos_q;
      nidx_q  <= cnt_q;
      i_q     <= cnt_q;
      sidx_q  <= '0;
      st_q    <= cur_st_q;
      last_q  <= in_last_i;
    end
    if (cmd_i.xlat) newc_q <= newc;
    if (lk_req) begin
      byp_q  <= (lk_c == 8'd0) || (32'(lk_st) >= STATES);
      bval_q <= (lk_c == 8'd0) ? lk_st : 8'd0;
    end
    if (cmd_i.look) begin
      i_q    <= i_n;
      sidx_q <= sidx_n;
      st_q   <= st_n;
      bp_q   <= bp_n;
      bl_q   <= bl_n;
      ovf_q  <= ovf_n;
      if (act == ACT_END) ms_q <= base_q + POS_W'(sidx_n);
    end
    if (cmd_i.emit) begin
      out_user_q <= bv_q;
      out_data_q <= bv_q ? {ovf_q, LEN_W'(bl_q), bp_q, POS_W'(base_q + POS_W'(sidx_q))}
                         : {ovf_q, 47'd0};
    end
  end

  // per-string control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cur_st_q  <= '0;
      cnt_q     <= '0;
      bv_q      <= 1'b0;
      decided_q <= 1'b0;
    end else begin
      if (acc_text) begin
        if (decided_q && in_last_i) begin
          pos_q     <= '0;
          cur_st_q  <= '0;
          cnt_q     <= '0;
          bv_q      <= 1'b0;
          decided_q <= 1'b0;
        end else begin
          pos_q <= POS_W'(pos_q + POS_W'(1));
        end
      end
      if (cmd_i.look) begin
        bv_q <= bv_n;
        if (act == ACT_END) begin
          cur_st_q <= st_n;
          cnt_q    <= (st_n != 8'd0) ? IW'(nidx_q + IW'(1) - sidx_n) : '0;
        end
      end
      if (cmd_i.emit) begin
        if (last_q) begin
          pos_q     <= '0;
          cur_st_q  <= '0;
          cnt_q     <= '0;
          bv_q      <= 1'b0;
          decided_q <= 1'b0;
        end else begin
          decided_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  assign sts_o.clr_done = (clr_q == TAW'(TDEPTH - 1));
  assign sts_o.is_text  = (in_user_i == OP_TEXT);
  assign sts_o.decided  = decided_q;
  assign sts_o.act      = act;
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

[sv/trie_multi_pattern_matcher_core.sv]
`timescale 1ns / 1ps
// Top level of the trie multi-pattern matcher: sequencer plus datapath.
// Depends on tpm_pkg, tpm_ctrl and tpm_datapath.
//
// Usage:
//  The slave stream carries table writes and text bytes; tuser selects the
//  kind (transition write, translation write, text byte), tlast marks the
//  final byte of a string. The master stream returns one result per string:
//  tuser is found, tdata holds start, pattern, length and overflow.
//  anchored_mode is written through cfg_we_i / cfg_wdata_i while idle.
//  After reset the transition memory is swept to zero, during which
//  s_axis_tready stays low. Translation starts as identity. A text byte
//  passes through intake, translation read and transition read; after a
//  failed partial match each buffered byte is replayed by a replay buffer
//  read plus a transition read, and the new byte then gets a second
//  lookup. A result is held in an output register; if the receiver
//  stalls, the block waits in its result state until the register is
//  free. Bytes after a decided string are taken without table reads.
module trie_multi_pattern_matcher_core
  import tpm_pkg::*;
#(
  parameter int unsigned STATES  = STATES_DEF,
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,      // anchored_mode
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // code[7:0] state_index[15:8] next_state[23:16] match_tag[31:24]
  // translated_code[39:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [IN_USER_W-1:0]  s_axis_tuser,     // op[1:0]
  input  logic                  s_axis_tlast,     // last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // start_position[31:0] pattern_index[39:32] match_length[46:40] overflow[47]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser      // found
);

  tpm_cmd_t cmd;
  tpm_sts_t sts;

  tpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpm_datapath #(
    .STATES  (STATES),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // no match reports zero fields apart from overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[46:0] == 47'd0)
    else $error("result without match has nonzero fields");

  // an undecided text byte goes on to translation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TEXT && !sts.decided
    |=> cmd.xlat)
    else $error("text byte not translated");

  // a replay step is followed by the replay lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.look && sts.act == ACT_RING |=> cmd.ring)
    else $error("replay read skipped");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for trie_multi_pattern_matcher_core: loads trie and translation
// tables, streams text strings and checks every result against a predictor.
// Depends on tpm_pkg and the matcher RTL.

class match_scoreboard;
  typedef struct {
    bit found;
    int unsigned start;
    bit [7:0] pattern;
    bit [6:0] len;
    bit ovf;
  } match_t;

  bit [15:0] trans_mem [65536];
  bit [7:0] xlat_mem [256];
  bit [7:0] replay [64];
  int unsigned buf_cnt, cur_state, text_pos, m_start, best_pat, best_len;
  bit best_ok, decided, anchored;
  match_t pending_matches [$];
  int errors;

  function new();
    foreach (xlat_mem[k]) xlat_mem[k] = k[7:0];
    clear_string();
  endfunction

  function void clear_string();
    cur_state = 0; text_pos = 0; m_start = 0; best_pat = 0;
    best_ok = 0; best_len = 0; decided = 0; buf_cnt = 0;
  endfunction

  function void push_match(bit ovf);
    match_t m;
    m.found = best_ok;
    m.start = best_ok ? m_start : 0;
    m.pattern = best_ok ? best_pat[7:0] : 8'd0;
    m.len = best_ok ? best_len[6:0] : 7'd0;
    m.ovf = ovf;
    pending_matches.push_back(m);
    decided = 1;
  endfunction

  function void note_transfer(tpm_pkg::op_e op, bit [7:0] code, bit [7:0] si,
                              bit [7:0] ns, bit [7:0] tag, bit [7:0] tc, bit last);
    bit [7:0] w [65];
    int unsigned n, i, sidx, st, base, pos, e;
    bit done;
    if (op == tpm_pkg::OP_TRANS) begin
      if (code != 0) trans_mem[{code, si}] = {tag, ns};
      return;
    end
    if (op == tpm_pkg::OP_XLAT) begin
      xlat_mem[code] = tc;
      return;
    end
    if (op != tpm_pkg::OP_TEXT) return;
    pos = text_pos;
    text_pos++;
    if (decided) begin
      if (last) clear_string();
      return;
    end
    n = (buf_cnt > 64) ? 64 : buf_cnt;
    for (int k = 0; k < n; k++) w[k] = replay[k];
    w[n] = xlat_mem[code];
    n++;
    base = pos - (n - 1);
    st = cur_state;
    sidx = 0;
    i = n - 1;
    done = 0;
    while (i < n && !done) begin
      e = (w[i] == 0) ? st : trans_mem[{w[i], st[7:0]}];
      if (e != 0) begin
        if (st == 0) sidx = i;
        if (i - sidx + 1 > 64) begin
          m_start = base + sidx;
          push_match(1);
          done = 1;
        end else begin
          st = e & 8'hff;
          if (((e >> 8) & 8'hff) != 0) begin
            best_ok = 1;
            best_pat = ((e >> 8) & 8'hff) - 1;
            best_len = i - sidx + 1;
            if (st == 0) begin
              m_start = base + sidx;
              push_match(0);
              done = 1;
            end
          end
          i++;
        end
      end else if (anchored || (st != 0 && best_ok)) begin
        m_start = base + sidx;
        push_match(0);
        done = 1;
      end else begin
        i = (st != 0) ? sidx + 1 : i + 1;
        st = 0;
      end
    end
    if (!done) begin
      cur_state = st;
      if (st != 0) begin
        buf_cnt = n - sidx;
        for (int k = 0; k < buf_cnt; k++) replay[k] = w[sidx + k];
        m_start = base + sidx;
      end else begin
        buf_cnt = 0;
      end
      if (last) push_match(0);
    end
    if (last) clear_string();
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endfunction

  function void check_result(bit found, bit [47:0] d);
    match_t m;
    if (pending_matches.size() == 0) begin
      report("unexpected result");
      return;
    end
    m = pending_matches.pop_front();
    if (found != m.found) report($sformatf("found %0d want %0d", found, m.found));
    if (d[31:0] != m.start) report($sformatf("start %0d want %0d", d[31:0], m.start));
    if (d[39:32] != m.pattern)
      report($sformatf("pattern %0d want %0d", d[39:32], m.pattern));
    if (d[46:40] != m.len) report($sformatf("length %0d want %0d", d[46:40], m.len));
    if (d[47] != m.ovf) report($sformatf("overflow %0d want %0d", d[47], m.ovf));
  endfunction
endclass

module tb;
  import tpm_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0, cfg_wdata_i = 0;
  logic s_axis_tvalid = 0, s_axis_tlast = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tuser;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  match_scoreboard sb = new();
  int burst_left = 0;
  int n_sent = 0;
  int unsigned stall_cnt = 0;

  trie_multi_pattern_matcher_core dut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: stall style is picked by bits 10:9 of a free-running counter
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    stall_cnt <= stall_cnt + 1;
    case (stall_cnt[10:9])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(3) != 0);
      2'd2: m_axis_tready <= stall_cnt[3];
      default: m_axis_tready <= ($urandom_range(7) == 0);
    endcase
  end

  task automatic send(logic [1:0] op, bit [7:0] code, bit [7:0] si = 0,
                      bit [7:0] ns = 0, bit [7:0] tag = 0, bit [7:0] tc = 0,
                      bit last = 0);
    if (burst_left == 0) begin
      int gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(4) == 0) ? 200 : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {tc, tag, ns, si, code};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    sb.note_transfer(op_e'(op), code, si, ns, tag, tc, last);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send(OP_TEXT, s[k], 0, 0, 0, 0, k == s.len() - 1);
  endtask

  task automatic trans(bit [7:0] c, bit [7:0] s, bit [7:0] ns, bit [7:0] tag);
    send(OP_TRANS, c, s, ns, tag);
  endtask

  task automatic drain_and_config(bit mode);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_matches.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.anchored = mode;
  endtask

  task automatic random_string();
    int len;
    bit [7:0] c;
    len = ($urandom_range(15) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) c = $urandom_range(255);
      else if (len > 40) c = (k == 0) ? "y" : "z";
      else c = "a" + $urandom_range(4);
      send(OP_TEXT, c, $urandom, $urandom, $urandom, $urandom, k == len - 1);
    end
  endtask

  task automatic random_phase(int items);
    int stop_at = n_sent + items;
    for (int s = 0; s < 8; s++)
      for (int c = 0; c < 5; c++)
        if ($urandom_range(2) != 0)
          trans("a" + c, s, $urandom_range(7),
                ($urandom_range(2) == 0) ? $urandom_range(1, 255) : 0);
    trans("z", 3, 3, 0);
    trans("y", 0, 3, 0);
    while (n_sent < stop_at) begin
      case ($urandom_range(19))
        0: send(OP_TRANS, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: send(OP_XLAT, $urandom, $urandom, $urandom, $urandom,
                ($urandom_range(1) == 0) ? 8'd0 : "a" + $urandom_range(4), $urandom);
        2: send(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        3: trans("a" + $urandom_range(4), $urandom_range(7), $urandom_range(7),
                 $urandom_range(3) == 0 ? $urandom_range(1, 255) : 0);
        default: random_string();
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // trie: "ab" -> 0, "abc" -> 1, "q" -> 254, "y" "z"* loops forever
    trans("a", 0, 1, 0);
    trans("b", 1, 2, 1);
    trans("c", 2, 0, 2);
    trans("q", 0, 0, 255);
    trans("y", 0, 3, 0);
    trans("z", 3, 3, 0);
    trans(8'd0, 0, 5, 9);
    send(OP_XLAT, "A", 0, 0, 0, "a");
    send(OP_XLAT, "-", 0, 0, 0, 8'd0);
    send(2'd3, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1);
    send_text("xxabcx");
    send_text("xabd");
    send_text("aaxab");
    send_text("a-bq");
    send_text("Ab");
    send_text("-");
    send_text("xyz");
    send_text({"y", {70{"z"}}});
    drain_and_config(1);
    send_text("abc");
    send_text("xab");
    send_text("abd");
    drain_and_config(0);
    random_phase(600);
    drain_and_config(1);
    random_phase(500);
    drain_and_config(0);
    random_phase(600);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[files.f]
sv/tpm_pkg.sv
sv/tpm_ctrl.sv
sv/tpm_datapath.sv
sv/trie_multi_pattern_matcher_core.sv
bench/tb.sv
